// File: rtl/vlf_pkg.sv
// ----------------------------------------------------------------------------
// vlf_pkg
// Shared widths, register indexes, sequencer states and helpers for the
// viewport letterbox fit block.
// ----------------------------------------------------------------------------
package vlf_pkg;

  localparam int MAX_DIM     = 4096;
  localparam int FRAC_BITS   = 16;
  localparam int DIM_W       = 13;
  localparam int SRC_W       = 17;   // camera width reaches 17 bits
  localparam int ASPECT_W    = 16;
  localparam int ASPECT_FRAC = 12;
  localparam int OFF_W       = 14;
  localparam int POS_W       = 15;
  localparam int PX_W        = 16;   // internal position, before truncation
  localparam int MAG_W       = 15;
  localparam int NORM_W      = 24;
  localparam int PROD_W      = 30;
  localparam int MUL_A_W     = 17;
  localparam int MUL_B_W     = 16;
  localparam int DIVN_W      = MAG_W + FRAC_BITS;
  localparam int DIVD_W      = SRC_W;
  localparam int DCNT_W      = $clog2(DIVN_W + 1);
  localparam int SHIFT_W     = 5;
  localparam int MAX_SHIFT   = 20;
  localparam int CFG_W       = 14;
  localparam int CFG_IDX_W   = 2;
  localparam int SIZE_CAP    = (MAX_DIM < 8191) ? MAX_DIM : 8191;

  localparam logic [1:0] MODE_FIXED    = 2'd0;
  localparam logic [1:0] MODE_BEST_FIT = 2'd1;
  localparam logic [1:0] MODE_KEEP_AR  = 2'd2;
  localparam logic [1:0] MODE_STRETCH  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANCHOR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SRC, ST_CHK, ST_SHIFT, ST_KW, ST_KH, ST_MULW, ST_MULH,
    ST_CR1, ST_CR2, ST_CR3, ST_DIVA, ST_PLACE, ST_NORM, ST_NORMW, ST_LOAD
  } vlf_state_t;

  typedef struct packed {
    logic              start;
    logic [DIVN_W-1:0] num;
    logic [DIVD_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIVN_W-1:0] quo;
  } div_rsp_t;

  // clamp a size to the field cap
  function automatic logic [DIM_W-1:0] sat_size(input logic [32:0] v);
    logic [32:0] cap;
    cap = 33'(SIZE_CAP);
    sat_size = (v > cap) ? DIM_W'(SIZE_CAP) : v[DIM_W-1:0];
  endfunction

endpackage

// File: rtl/vlf_div.sv
// ----------------------------------------------------------------------------
// vlf_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vlf_div
  import vlf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy_r;
  logic              done_r;
  logic [DCNT_W-1:0] cnt_r;
  logic [DIVD_W-1:0] rem_r;
  logic [DIVD_W-1:0] den_r;
  logic [DIVN_W-1:0] quo_r;
  logic [DIVD_W:0]   shifted;
  logic [DIVD_W+1:0] diff;
  logic              neg;
  logic [DIVD_W-1:0] rem_nxt;
  logic [DIVN_W-1:0] quo_nxt;

  always_comb begin
    shifted = {rem_r, quo_r[DIVN_W-1]};
    diff    = {1'b0, shifted} - {2'b00, den_r};
    neg     = diff[DIVD_W+1];
    rem_nxt = neg ? shifted[DIVD_W-1:0] : diff[DIVD_W-1:0];
    quo_nxt = {quo_r[DIVN_W-2:0], ~neg};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= DCNT_W'(DIVN_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DCNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.num;
      den_r <= req.den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

// File: rtl/viewport_letterbox_fit.sv
// ----------------------------------------------------------------------------
// viewport_letterbox_fit
// Viewport rectangle for a source shown inside a render target.
// ----------------------------------------------------------------------------
// One request at a time: in_stall stays high from the transfer until the
// result is loaded into the output register; the load waits while the
// previous result is held by out_stall. Most of the work is done by the
// single serial divider: keep-aspect uses one quotient, integer best fit two
// (none if the source is shifted down to fit), fixed and stretch none, and
// each of the four normalized outputs one more unless its target dimension
// is zero. Zero-source requests skip the divider. A new request may be taken
// while the previous result still waits on out_stall.
module viewport_letterbox_fit
  import vlf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [DIM_W-1:0]     in_target_width,
  input  logic [DIM_W-1:0]     in_target_height,
  input  logic [DIM_W-1:0]     in_source_width,
  input  logic [DIM_W-1:0]     in_source_height,
  input  logic                 in_source_is_camera,
  input  logic [ASPECT_W-1:0]  in_camera_aspect,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [POS_W-1:0]  out_pos_x,
  output logic signed [POS_W-1:0]  out_pos_y,
  output logic [DIM_W-1:0]         out_size_w,
  output logic [DIM_W-1:0]         out_size_h,
  output logic signed [NORM_W-1:0] out_norm_x,
  output logic signed [NORM_W-1:0] out_norm_y,
  output logic signed [NORM_W-1:0] out_norm_w,
  output logic signed [NORM_W-1:0] out_norm_h,
  output logic                     out_zero_source
);

  // config
  logic [1:0]       fit_mode_r;
  logic [3:0]       anchor_r;
  logic [OFF_W-1:0] off_x_r;
  logic [OFF_W-1:0] off_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_mode_r <= MODE_KEEP_AR;
      anchor_r   <= '0;
      off_x_r    <= '0;
      off_y_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FIT_MODE: fit_mode_r <= cfg_wdata[1:0];
        CFG_ANCHOR:   anchor_r   <= cfg_wdata[3:0];
        CFG_OFFSET_X: off_x_r    <= cfg_wdata;
        CFG_OFFSET_Y: off_y_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  vlf_state_t state_r, state_nxt;

  logic [DIM_W-1:0]    tw_r, th_r, swi_r, shi_r;
  logic                cam_r;
  logic [ASPECT_W-1:0] asp_r;
  logic [SRC_W-1:0]    sw_r;
  logic [DIM_W-1:0]    sh_r;
  logic                zero_r;
  logic [DIM_W-1:0]    vw_r, vh_r;
  logic [SRC_W:0]      tws_r;
  logic [SRC_W:0]      ths_r;
  logic [SHIFT_W-1:0]  m_r;
  logic [DIM_W-1:0]    kw_r;
  logic [DIM_W-1:0]    k_r;
  logic [PROD_W-1:0]   prod1_r, prod2_r;
  logic                ge_r;
  logic signed [PX_W-1:0] px_r, py_r;
  logic [1:0]          idx_r;
  logic                neg_r;
  logic [NORM_W-1:0]   nrm_r [4];

  logic                   out_valid_r;
  logic [POS_W-1:0]       o_px_r, o_py_r;
  logic [DIM_W-1:0]       o_w_r, o_h_r;
  logic [NORM_W-1:0]      o_nx_r, o_ny_r, o_nw_r, o_nh_r;
  logic                   o_zero_r;

  div_req_t div_req;
  div_rsp_t div_rsp;

  vlf_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  // shared multiplier
  logic [MUL_A_W-1:0]         mul_a;
  logic [MUL_B_W-1:0]         mul_b;
  logic [MUL_A_W+MUL_B_W-1:0] prod;

  assign prod = mul_a * mul_b;

  logic in_xfer, out_xfer;
  logic src_zero, too_big, shift_go, cross_ge, load_ok;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;
  assign src_zero = (sw_r == '0) || (sh_r == '0);
  assign too_big  = ({4'b0, tw_r} < sw_r) || (th_r < sh_r);
  assign shift_go = (m_r < SHIFT_W'(MAX_SHIFT)) &&
                    ((tws_r < {1'b0, sw_r}) || (ths_r < {5'b0, sh_r}));
  assign cross_ge = prod1_r >= prod2_r;
  assign load_ok  = !out_valid_r || !out_stall;

  // normalize operand select
  logic signed [PX_W-1:0] nval;
  logic [DIM_W-1:0]       ntgt;
  logic                   nneg;
  logic [PX_W-1:0]        nabs;
  logic [NORM_W-1:0]      nsat;

  always_comb begin
    unique case (idx_r)
      2'd0:    nval = px_r;
      2'd1:    nval = py_r;
      2'd2:    nval = PX_W'({1'b0, vw_r});
      default: nval = PX_W'({1'b0, vh_r});
    endcase
    ntgt = idx_r[0] ? th_r : tw_r;
    nneg = nval[PX_W-1];
    nabs = nneg ? PX_W'(-nval) : PX_W'(nval);
    if (neg_r) begin
      nsat = (div_rsp.quo > DIVN_W'(1 << (NORM_W-1))) ? {1'b1, {(NORM_W-1){1'b0}}}
                                                       : NORM_W'(-div_rsp.quo);
    end else begin
      nsat = (div_rsp.quo > DIVN_W'((1 << (NORM_W-1)) - 1)) ? {1'b0, {(NORM_W-1){1'b1}}}
                                                            : div_rsp.quo[NORM_W-1:0];
    end
  end

  // placement
  logic signed [PX_W-1:0] dx, dy, hx, hy, pxc, pyc;

  always_comb begin
    dx = PX_W'(signed'({1'b0, tw_r})) - PX_W'(signed'({1'b0, vw_r}));
    dy = PX_W'(signed'({1'b0, th_r})) - PX_W'(signed'({1'b0, vh_r}));
    hx = (dx + signed'(PX_W'(dx[PX_W-1]))) >>> 1;   // truncate toward zero
    hy = (dy + signed'(PX_W'(dy[PX_W-1]))) >>> 1;
    priority if (anchor_r[0]) pxc = '0;
    else if (anchor_r[1])     pxc = dx;
    else                      pxc = hx;
    priority if (anchor_r[2]) pyc = '0;
    else if (anchor_r[3])     pyc = dy;
    else                      pyc = hy;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_xfer) state_nxt = ST_SRC;
      ST_SRC:   state_nxt = ST_CHK;
      ST_CHK: begin
        if (src_zero) begin
          state_nxt = ST_LOAD;
        end else begin
          unique case (fit_mode_r)
            MODE_BEST_FIT: state_nxt = too_big ? ST_SHIFT : ST_KW;
            MODE_KEEP_AR:  state_nxt = ST_CR1;
            default:       state_nxt = ST_PLACE;
          endcase
        end
      end
      ST_SHIFT: if (!shift_go) state_nxt = ST_PLACE;
      ST_KW:    if (div_rsp.done) state_nxt = ST_KH;
      ST_KH:    if (div_rsp.done) state_nxt = ST_MULW;
      ST_MULW:  state_nxt = ST_MULH;
      ST_MULH:  state_nxt = ST_PLACE;
      ST_CR1:   state_nxt = ST_CR2;
      ST_CR2:   state_nxt = ST_CR3;
      ST_CR3:   state_nxt = ST_DIVA;
      ST_DIVA:  if (div_rsp.done) state_nxt = ST_PLACE;
      ST_PLACE: state_nxt = ST_NORM;
      ST_NORM: begin
        if (ntgt != '0)          state_nxt = ST_NORMW;
        else if (idx_r == 2'd3)  state_nxt = ST_LOAD;
      end
      ST_NORMW: if (div_rsp.done) state_nxt = (idx_r == 2'd3) ? ST_LOAD : ST_NORM;
      ST_LOAD:  if (load_ok) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // unit control
  always_comb begin
    in_stall    = (state_r != ST_IDLE);
    div_req     = '0;
    mul_a       = '0;
    mul_b       = '0;
    unique case (state_r)
      ST_SRC: begin
        mul_a = MUL_A_W'(th_r);
        mul_b = asp_r;
      end
      ST_CHK: begin
        div_req.start = !src_zero && (fit_mode_r == MODE_BEST_FIT) && !too_big;
        div_req.num   = DIVN_W'(tw_r);
        div_req.den   = sw_r;
      end
      ST_KW: begin
        div_req.start = div_rsp.done;
        div_req.num   = DIVN_W'(th_r);
        div_req.den   = DIVD_W'(sh_r);
      end
      ST_MULW: begin
        mul_a = sw_r;
        mul_b = MUL_B_W'(k_r);
      end
      ST_MULH: begin
        mul_a = MUL_A_W'(sh_r);
        mul_b = MUL_B_W'(k_r);
      end
      ST_CR1: begin
        mul_a = MUL_A_W'(tw_r);
        mul_b = MUL_B_W'(sh_r);
      end
      ST_CR2: begin
        mul_a = sw_r;
        mul_b = MUL_B_W'(th_r);
      end
      ST_CR3: begin
        div_req.start = 1'b1;
        div_req.num   = DIVN_W'(cross_ge ? prod2_r : prod1_r);
        div_req.den   = cross_ge ? DIVD_W'(sh_r) : sw_r;
      end
      ST_NORM: begin
        div_req.start = (ntgt != '0);
        div_req.num   = {nabs[MAG_W-1:0], {FRAC_BITS{1'b0}}};
        div_req.den   = DIVD_W'(ntgt);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_LOAD && load_ok) begin
        out_valid_r <= 1'b1;
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        tw_r   <= in_target_width;
        th_r   <= in_target_height;
        swi_r  <= in_source_width;
        shi_r  <= in_source_height;
        cam_r  <= in_source_is_camera;
        asp_r  <= in_camera_aspect;
        zero_r <= 1'b0;
        idx_r  <= '0;
      end
      ST_SRC: begin
        if (cam_r) begin
          sw_r <= (asp_r != '0) ? prod[ASPECT_FRAC+SRC_W-1:ASPECT_FRAC]
                                : SRC_W'(tw_r);
          sh_r <= th_r;
        end else begin
          sw_r <= SRC_W'(swi_r);
          sh_r <= shi_r;
        end
      end
      ST_CHK: begin
        zero_r <= src_zero;
        tws_r  <= (SRC_W+1)'({tw_r, 1'b0});
        ths_r  <= (SRC_W+1)'({th_r, 1'b0});
        m_r    <= SHIFT_W'(1);
        if (fit_mode_r == MODE_FIXED) begin
          vw_r <= sat_size(33'(sw_r));
          vh_r <= sat_size(33'(sh_r));
        end else begin
          vw_r <= sat_size(33'(tw_r));
          vh_r <= sat_size(33'(th_r));
        end
      end
      ST_SHIFT: begin
        if (shift_go) begin
          m_r   <= m_r + 1'b1;
          tws_r <= tws_r[SRC_W] ? tws_r : {tws_r[SRC_W-1:0], 1'b0};
          ths_r <= ths_r[SRC_W] ? ths_r : {ths_r[SRC_W-1:0], 1'b0};
        end else begin
          vw_r <= sat_size(33'(sw_r >> m_r));
          vh_r <= sat_size(33'(sh_r >> m_r));
        end
      end
      ST_KW: if (div_rsp.done) kw_r <= div_rsp.quo[DIM_W-1:0];
      ST_KH: begin
        if (div_rsp.done) begin
          k_r <= (div_rsp.quo[DIM_W-1:0] < kw_r) ? div_rsp.quo[DIM_W-1:0] : kw_r;
        end
      end
      ST_MULW: vw_r <= sat_size(prod);
      ST_MULH: vh_r <= sat_size(prod);
      ST_CR1:  prod1_r <= prod[PROD_W-1:0];
      ST_CR2:  prod2_r <= prod[PROD_W-1:0];
      ST_CR3:  ge_r <= cross_ge;
      ST_DIVA: begin
        if (div_rsp.done) begin
          if (ge_r) vw_r <= sat_size(33'(div_rsp.quo));
          else      vh_r <= sat_size(33'(div_rsp.quo));
        end
      end
      ST_PLACE: begin
        px_r <= pxc + PX_W'(signed'(off_x_r));
        py_r <= pyc + PX_W'(signed'(off_y_r));
      end
      ST_NORM: begin
        neg_r <= nneg;
        if (ntgt == '0) begin
          nrm_r[idx_r] <= '0;
          idx_r        <= idx_r + 1'b1;
        end
      end
      ST_NORMW: begin
        if (div_rsp.done) begin
          nrm_r[idx_r] <= nsat;
          idx_r        <= idx_r + 1'b1;
        end
      end
      ST_LOAD: begin
        if (load_ok) begin
          o_zero_r <= zero_r;
          o_px_r   <= zero_r ? '0 : px_r[POS_W-1:0];
          o_py_r   <= zero_r ? '0 : py_r[POS_W-1:0];
          o_w_r    <= zero_r ? '0 : vw_r;
          o_h_r    <= zero_r ? '0 : vh_r;
          o_nx_r   <= zero_r ? '0 : nrm_r[0];
          o_ny_r   <= zero_r ? '0 : nrm_r[1];
          o_nw_r   <= zero_r ? '0 : nrm_r[2];
          o_nh_r   <= zero_r ? '0 : nrm_r[3];
        end
      end
      default: ;
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_pos_x       = signed'(o_px_r);
  assign out_pos_y       = signed'(o_py_r);
  assign out_size_w      = o_w_r;
  assign out_size_h      = o_h_r;
  assign out_norm_x      = signed'(o_nx_r);
  assign out_norm_y      = signed'(o_ny_r);
  assign out_norm_w      = signed'(o_nw_r);
  assign out_norm_h      = signed'(o_nh_r);
  assign out_zero_source = o_zero_r;

  // a quotient only comes back to a state that waits for one
  a_div_done_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_KW || state_r == ST_KH ||
                      state_r == ST_DIVA || state_r == ST_NORMW))
    else $error("divider result with no consumer");

  // new results appear only out of the load state
  a_load_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_LOAD))
    else $error("result shown without load");

  // zero source result carries no rectangle
  a_zero_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && o_zero_r) |-> (o_w_r == '0 && o_h_r == '0 && o_nw_r == '0))
    else $error("zero source with nonzero size");

  // divider start never comes back to back
  a_one_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |=> !div_req.start)
    else $error("back to back divider start");

endmodule
